### hw/rtl/pite_pkg.sv
// shared widths, types and helper functions for the point-in-triangle edge test
package pite_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = DIFF_WIDTH + COORD_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 2;
	localparam int LATENCY     = 6;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;

	function automatic diff_t sub_coord(input coord_t a, input coord_t b);
		diff_t ea;
		diff_t eb;
		ea = DIFF_WIDTH'(a);
		eb = DIFF_WIDTH'(b);
		return ea - eb;
	endfunction

	function automatic sum_t add3(input prod_t a, input prod_t b, input prod_t c);
		sum_t ea;
		sum_t eb;
		sum_t ec;
		ea = SUM_WIDTH'(a);
		eb = SUM_WIDTH'(b);
		ec = SUM_WIDTH'(c);
		return ea + eb + ec;
	endfunction

endpackage

### hw/rtl/point_in_triangle_edge_test.sv
// point-in-triangle edge function test, six register stages
//
//  channel  | handshake            | fields
//  ---------+----------------------+----------------------------------------
//  command  | start / busy         | point_x point_y v0_x v0_y v1_x v1_y v2_x v2_y
//  result   | res_valid (strobe)   | inside_res
//
// one beat enters per cycle while busy is low; its result strobes once the beat has passed all six register stages.
// the pipeline depth is set by two multiplier stages (orientation and edge products),
// each with a difference stage before it and a sum stage after it.
// busy is high only in the first cycle after reset; reset clears the valid bits.
// results cannot be held off, so nothing in the pipeline ever stalls.
module point_in_triangle_edge_test (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pite_pkg::coord_t      point_x,
	input  pite_pkg::coord_t      point_y,
	input  pite_pkg::coord_t      v0_x,
	input  pite_pkg::coord_t      v0_y,
	input  pite_pkg::coord_t      v1_x,
	input  pite_pkg::coord_t      v1_y,
	input  pite_pkg::coord_t      v2_x,
	input  pite_pkg::coord_t      v2_y,
	output logic                  res_valid,
	output logic                  inside_res
);

	typedef struct packed {
		pite_pkg::coord_t px;
		pite_pkg::coord_t py;
		pite_pkg::coord_t x0;
		pite_pkg::coord_t y0;
		pite_pkg::coord_t x1;
		pite_pkg::coord_t y1;
		pite_pkg::coord_t x2;
		pite_pkg::coord_t y2;
	} pts_t;

	logic busy_q;
	logic accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	pts_t pts_s1, pts_s2, pts_s3;
	pite_pkg::diff_t sd0_s1, sd1_s1, sd2_s1;
	pite_pkg::prod_t sp0_s2, sp1_s2, sp2_s2;
	logic neg_s3;

	// stage 4: selected edge differences, multiplicands
	pite_pkg::diff_t ed_s4 [9];
	pite_pkg::coord_t em_s4 [9];
	pite_pkg::prod_t ep_s5 [9];
	logic inside_s6;

	pite_pkg::coord_t ax, ay, bx, by;
	pite_pkg::sum_t s_sum, e1, e2, e3;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// stage 1: capture and orientation differences
	always_ff @(posedge clk) begin
		pts_s1 <= '{px: point_x, py: point_y, x0: v0_x, y0: v0_y,
			x1: v1_x, y1: v1_y, x2: v2_x, y2: v2_y};
		sd0_s1 <= pite_pkg::sub_coord(v0_y, v1_y);
		sd1_s1 <= pite_pkg::sub_coord(v2_y, v0_y);
		sd2_s1 <= pite_pkg::sub_coord(v1_y, v2_y);
	end

	// stage 2: orientation products
	always_ff @(posedge clk) begin
		pts_s2 <= pts_s1;
		sp0_s2 <= sd0_s1 * pts_s1.x2;
		sp1_s2 <= sd1_s1 * pts_s1.x1;
		sp2_s2 <= sd2_s1 * pts_s1.x0;
	end

	// stage 3: signed-area sign
	assign s_sum = pite_pkg::add3(sp0_s2, sp1_s2, sp2_s2);

	always_ff @(posedge clk) begin
		pts_s3 <= pts_s2;
		neg_s3 <= s_sum[pite_pkg::SUM_WIDTH-1];
	end

	// stage 4: pick edge vertices, clockwise order swaps v1 and v2
	always_comb begin
		if (neg_s3) begin
			ax = pts_s3.x2;
			ay = pts_s3.y2;
			bx = pts_s3.x1;
			by = pts_s3.y1;
		end else begin
			ax = pts_s3.x1;
			ay = pts_s3.y1;
			bx = pts_s3.x2;
			by = pts_s3.y2;
		end
	end

	always_ff @(posedge clk) begin
		ed_s4[0] <= pite_pkg::sub_coord(pts_s3.py, by);
		em_s4[0] <= ax;
		ed_s4[1] <= pite_pkg::sub_coord(ay, pts_s3.py);
		em_s4[1] <= bx;
		ed_s4[2] <= pite_pkg::sub_coord(by, ay);
		em_s4[2] <= pts_s3.px;
		ed_s4[3] <= pite_pkg::sub_coord(pts_s3.y0, pts_s3.py);
		em_s4[3] <= ax;
		ed_s4[4] <= pite_pkg::sub_coord(ay, pts_s3.y0);
		em_s4[4] <= pts_s3.px;
		ed_s4[5] <= pite_pkg::sub_coord(pts_s3.py, ay);
		em_s4[5] <= pts_s3.x0;
		ed_s4[6] <= pite_pkg::sub_coord(pts_s3.y0, by);
		em_s4[6] <= pts_s3.px;
		ed_s4[7] <= pite_pkg::sub_coord(pts_s3.py, pts_s3.y0);
		em_s4[7] <= bx;
		ed_s4[8] <= pite_pkg::sub_coord(by, pts_s3.py);
		em_s4[8] <= pts_s3.x0;
	end

	// stage 5: edge products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			ep_s5[i] <= ed_s4[i] * em_s4[i];
		end
	end

	// stage 6: edge sums, inside only when all three are strictly negative
	assign e1 = pite_pkg::add3(ep_s5[0], ep_s5[1], ep_s5[2]);
	assign e2 = pite_pkg::add3(ep_s5[3], ep_s5[4], ep_s5[5]);
	assign e3 = pite_pkg::add3(ep_s5[6], ep_s5[7], ep_s5[8]);

	always_ff @(posedge clk) begin
		inside_s6 <= e1[pite_pkg::SUM_WIDTH-1] && e2[pite_pkg::SUM_WIDTH-1]
			&& e3[pite_pkg::SUM_WIDTH-1];
	end

	assign res_valid  = vld_s6;
	assign inside_res = inside_s6;

endmodule

### hw/rtl/pite_checker.sv
// port-level checks for the point-in-triangle edge test and its bind
module pite_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input pite_pkg::coord_t v0_x,
	input pite_pkg::coord_t v0_y,
	input pite_pkg::coord_t v1_x,
	input pite_pkg::coord_t v1_y,
	input logic             res_valid,
	input logic             inside_res
);

	// every accepted beat strobes a result after the fixed latency
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(pite_pkg::LATENCY) res_valid)
		else $error("accepted beat produced no result");

	// no result strobes without a beat accepted at the matching edge
	a_result_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(start && !busy, pite_pkg::LATENCY))
		else $error("result strobe without accepted beat");

	// a triangle whose v0 and v1 coincide covers nothing
	a_degenerate_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && v0_x == v1_x && v0_y == v1_y)
		|-> ##(pite_pkg::LATENCY) !inside_res)
		else $error("degenerate triangle reported inside");

	// once out of reset the block never refuses a beat again
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

endmodule

bind point_in_triangle_edge_test pite_checker u_pite_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.v0_x       (v0_x),
	.v0_y       (v0_y),
	.v1_x       (v1_x),
	.v1_y       (v1_y),
	.res_valid  (res_valid),
	.inside_res (inside_res)
);
